/* rtl/hash_pkg.sv */
`default_nettype none

package hash_pkg;

  localparam int NUM_BUCKETS = 1024;
  localparam int BUCKET_WAYS = 4;

  localparam int KEY_W    = 20;
  localparam int VAL_W    = 20;
  localparam int RES_W    = VAL_W + 1;
  localparam int BUCKET_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int WAY_IW   = (BUCKET_WAYS > 1) ? $clog2(BUCKET_WAYS) : 1;

  typedef enum logic [1:0] {
    OP_PUT    = 2'd0,
    OP_GET    = 2'd1,
    OP_REMOVE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic clr_we;   // write zero to the valid row at the sweep counter
    logic start;    // capture request and read the bucket rows
    logic upd;      // resolve, write back and register the result
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last; // sweep counter is on the last row
  } dp_stat_t;

  // Bucket index; the bucket count is a power of two, so this is a mask.
  function automatic logic [BUCKET_W-1:0] bucket_of(input logic [KEY_W-1:0] key);
    logic [KEY_W-1:0] rem;
    rem = KEY_W'(key % NUM_BUCKETS);
    return rem[BUCKET_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/hash_ctrl.sv */
`default_nettype none

module hash_ctrl (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                start_i,
  input  hash_pkg::dp_stat_t stat_i,
  output hash_pkg::dp_cmd_t  cmd_o,
  output logic               busy_o
);
  import hash_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (stat_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start_i) state_d = ST_LOOK;
      end
      ST_LOOK: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_we = 1'b1;
      end
      ST_IDLE: begin
        busy_o      = 1'b0;
        cmd_o.start = start_i;
      end
      ST_LOOK: begin
        cmd_o.upd = 1'b1;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_look_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LOOK |=> state_q == ST_IDLE)
    else $error("lookup state held longer than one cycle");

  a_clear_no_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> !cmd_o.start && !cmd_o.upd)
    else $error("request issued during clearing sweep");

  a_clear_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(state_q) == ST_CLEAR && state_q == ST_IDLE |-> $past(stat_i.clr_last))
    else $error("clearing sweep ended early");
`endif

endmodule

`default_nettype wire

/* rtl/hash_dp.sv */
`default_nettype none

module hash_dp (
  input  wire                                     clk_i,
  input  wire                                     rst_ni,
  input  hash_pkg::dp_cmd_t                       cmd_i,
  output hash_pkg::dp_stat_t                      stat_o,
  input  wire  [1:0]                              operation_i,
  input  wire  [hash_pkg::KEY_W-1:0]              key_i,
  input  wire  [hash_pkg::VAL_W-1:0]              value_i,
  output logic                                    done_o,
  output logic signed [hash_pkg::RES_W-1:0]       result_value_o,
  output logic                                    found_o,
  output logic                                    status_o
);
  import hash_pkg::*;

  // bucket rows: valid bits, keys, values
  logic [BUCKET_WAYS-1:0]            vld_mem [NUM_BUCKETS];
  logic [BUCKET_WAYS-1:0][KEY_W-1:0] key_mem [NUM_BUCKETS];
  logic [BUCKET_WAYS-1:0][VAL_W-1:0] val_mem [NUM_BUCKETS];

  logic [BUCKET_WAYS-1:0]            vld_row_q;
  logic [BUCKET_WAYS-1:0][KEY_W-1:0] key_row_q;
  logic [BUCKET_WAYS-1:0][VAL_W-1:0] val_row_q;

  logic [BUCKET_W-1:0] clr_cnt_q, clr_cnt_d;
  logic [BUCKET_W-1:0] bucket_q, bucket_rd;
  op_e                 op_q;
  logic [KEY_W-1:0]    key_q;
  logic [VAL_W-1:0]    val_q;

  logic [BUCKET_WAYS-1:0] hit, free;
  logic [WAY_IW-1:0]      hit_idx, free_idx;
  logic                   any_hit, any_free;

  logic                              vld_we, key_we, val_we;
  logic [BUCKET_W-1:0]               vld_waddr;
  logic [BUCKET_WAYS-1:0]            vld_wdata, vld_new;
  logic [BUCKET_WAYS-1:0][KEY_W-1:0] key_new;
  logic [BUCKET_WAYS-1:0][VAL_W-1:0] val_new;
  logic signed [RES_W-1:0]           res_d;
  logic                              stat_d;

  logic                    done_q;
  logic signed [RES_W-1:0] res_q;
  logic                    found_q, status_q;

  assign bucket_rd = bucket_of(key_i);

  // clearing sweep counter
  assign clr_cnt_d       = clr_cnt_q + BUCKET_W'(1);
  assign stat_o.clr_last = (clr_cnt_q == BUCKET_W'(NUM_BUCKETS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_we) begin
      clr_cnt_q <= clr_cnt_d;
    end
  end

  // request capture and row read
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q      <= op_e'(operation_i);
      key_q     <= key_i;
      val_q     <= value_i;
      bucket_q  <= bucket_rd;
      vld_row_q <= vld_mem[bucket_rd];
      key_row_q <= key_mem[bucket_rd];
      val_row_q <= val_mem[bucket_rd];
    end
  end

  // way match and lowest free way
  always_comb begin
    hit      = '0;
    free     = '0;
    hit_idx  = '0;
    free_idx = '0;
    for (int w = 0; w < BUCKET_WAYS; w++) begin
      hit[w]  = vld_row_q[w] && (key_row_q[w] == key_q);
      free[w] = !vld_row_q[w];
    end
    for (int w = BUCKET_WAYS - 1; w >= 0; w--) begin
      if (hit[w])  hit_idx  = WAY_IW'(w);
      if (free[w]) free_idx = WAY_IW'(w);
    end
  end

  assign any_hit  = |hit;
  assign any_free = |free;

  // update decision
  always_comb begin
    key_new = key_row_q;
    val_new = val_row_q;
    vld_new = vld_row_q;
    key_we  = 1'b0;
    val_we  = 1'b0;
    vld_we  = 1'b0;
    stat_d  = 1'b0;
    res_d   = any_hit ? $signed({1'b0, val_row_q[hit_idx]}) : '1;
    case (op_q)
      OP_PUT: begin
        if (any_hit) begin
          val_new[hit_idx] = val_q;
          val_we           = cmd_i.upd;
        end else if (any_free) begin
          key_new[free_idx] = key_q;
          val_new[free_idx] = val_q;
          vld_new[free_idx] = 1'b1;
          key_we            = cmd_i.upd;
          val_we            = cmd_i.upd;
          vld_we            = cmd_i.upd;
        end else begin
          stat_d = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (any_hit) begin
          vld_new[hit_idx] = 1'b0;
          vld_we           = cmd_i.upd;
        end
      end
      default: begin
        // get, and the unused code: lookup only
      end
    endcase
  end

  // row write-back; the valid port is shared with the clearing sweep
  assign vld_waddr = cmd_i.clr_we ? clr_cnt_q : bucket_q;
  assign vld_wdata = cmd_i.clr_we ? '0 : vld_new;

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_we || vld_we) vld_mem[vld_waddr] <= vld_wdata;
    if (key_we) key_mem[bucket_q] <= key_new;
    if (val_we) val_mem[bucket_q] <= val_new;
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.upd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd) begin
      res_q    <= res_d;
      found_q  <= any_hit;
      status_q <= stat_d;
    end
  end

  assign done_o         = done_q;
  assign result_value_o = res_q;
  assign found_o        = found_q;
  assign status_o       = status_q;

endmodule

`default_nettype wire

/* rtl/hash_table_put_get_remove_top.sv */
// Flow: a request is captured with its bucket row, then resolved, written back
//   and registered onto the result ports (done_o high).
// Requests do not overlap: the bucket row is read, then written back, before the next.
// Reset: async active low; then a sweep clears all 1024 valid rows,
//   with busy_o high throughout. Results are never stalled by the receiver.
`default_nettype none

module hash_table_put_get_remove_top (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  // request beat: accepted when start_i is high and busy_o is low
  input  wire                               start_i,
  output logic                              busy_o,
  input  wire  [1:0]                        operation_i,
  input  wire  [hash_pkg::KEY_W-1:0]        key_i,
  input  wire  [hash_pkg::VAL_W-1:0]        value_i,
  // result beat: valid for the single cycle done_o is high
  output logic                              done_o,
  output logic signed [hash_pkg::RES_W-1:0] result_value_o,
  output logic                              found_o,
  output logic                              status_o
);
  import hash_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: clearing sweep, idle, lookup/update
  hash_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  // bucket memories, match logic, write-back and result register
  hash_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .operation_i    (operation_i),
    .key_i          (key_i),
    .value_i        (value_i),
    .done_o         (done_o),
    .result_value_o (result_value_o),
    .found_o        (found_o),
    .status_o       (status_o)
  );

`ifndef SYNTHESIS
  // every result beat traces back to an accepted request
  a_done_from_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 2))
    else $error("result beat without a matching request");

  // a dropped put never reports a hit
  a_drop_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o |-> !found_o && (result_value_o == '1))
    else $error("dropped put reports a stored value");

  // a hit returns a non-negative value, a miss returns all ones
  a_found_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (found_o && !result_value_o[RES_W-1]) ||
               (!found_o && (result_value_o == '1)))
    else $error("found flag and result value disagree");

  // the block is free to take the next request while the result is shown
  a_ready_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("busy while result beat is shown");
`endif

endmodule

`default_nettype wire
